>>> hdl/btct_pkg.sv
// Shared widths, constants and handoff types for the bulged triangle containment test.
package btct_pkg;

   // Coordinate field width (signed Q3.12)
   localparam int COORD_W = 16;
   // Bulge field width (Q1.8, full bulge is 256)
   localparam int BULGE_W = 9;
   localparam logic [BULGE_W-1:0] BULGE_FULL = 9'd256;

   // Corners and point are held at 2048 times their value, midpoints at the same scale
   localparam int CORNER_SHIFT = 11;
   localparam int MID_SHIFT    = 10;

   // Hexagon vertex, difference, product and cross widths
   localparam int VERT_W  = 28;
   localparam int DIFF_W  = 29;
   localparam int PROD_W  = 57;
   localparam int CROSS_W = 58;

   // Winding terms
   localparam int WDIFF_W = 17;
   localparam int WPROD_W = 34;
   localparam int WSUM_W  = 35;

   // Stage advance strobes handed to each edge unit
   typedef struct packed {
      logic s3;
      logic s4;
   } btct_adv_type;

   // Sign of one edge cross product
   typedef struct packed {
      logic neg;
      logic pos;
   } btct_sign_type;

endpackage

>>> hdl/bulged_triangle_containment_test_top.sv
// Top level of the bulged triangle containment test: five-stage pipeline.
//
// Usage:
//   Input channel (req_*): a beat carries a sample point, three triangle corners
//   (signed Q3.12) and a bulge amount (Q1.8, values above 256 act as 256). A beat
//   is taken at a rising edge with req_valid high and req_stall low.
//   Result channel (rsp_*): one beat per input beat, in order, with rsp_inside_res
//   (point inside the bulged hexagon or on its boundary) and rsp_degenerate (zero
//   winding, reported as outside). The receiver holds rsp_stall high to hold it.
//   Throughput: one beat per cycle while rsp_stall is low. The pipeline is input
//   register, hexagon vertices, edge deltas, 29x29 cross multiplies and result
//   register, which takes the cross signs.
//   Stall: each stage moves when the stage after it is empty or moving, so bubbles
//   close up while rsp_stall is high and req_stall rises only when every stage holds
//   a beat. No beat is lost or repeated.
//   Reset: synchronous, active high; clears all stage valid bits, the pipeline
//   comes out empty and ready.
module bulged_triangle_containment_test_top
   import btct_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_corner_a_x,
   input  logic signed [COORD_W-1:0] req_corner_a_y,
   input  logic signed [COORD_W-1:0] req_corner_b_x,
   input  logic signed [COORD_W-1:0] req_corner_b_y,
   input  logic signed [COORD_W-1:0] req_corner_c_x,
   input  logic signed [COORD_W-1:0] req_corner_c_y,
   input  logic        [BULGE_W-1:0] req_bulge_amount,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_inside_res,
   output logic                      rsp_degenerate
);

   // Corner scaled to vertex precision
   function automatic logic signed [VERT_W-1:0] corner_vert(
      input logic signed [COORD_W-1:0] c
   );
      corner_vert = {{(VERT_W-COORD_W-CORNER_SHIFT){c[COORD_W-1]}}, c,
                     {CORNER_SHIFT{1'b0}}};
   endfunction

   // Bulged midpoint of edge p,q pushed away from o
   function automatic logic signed [VERT_W-1:0] mid_vert(
      input logic signed [COORD_W-1:0] p,
      input logic signed [COORD_W-1:0] q,
      input logic signed [COORD_W-1:0] o,
      input logic        [BULGE_W-1:0] b
   );
      logic signed [COORD_W:0]   s;
      logic signed [COORD_W+1:0] d;
      logic signed [VERT_W-1:0]  push;
      s    = {p[COORD_W-1], p} + {q[COORD_W-1], q};
      d    = {s[COORD_W], s} - {o[COORD_W-1], o, 1'b0};
      push = VERT_W'(d) * VERT_W'($signed({1'b0, b}));
      mid_vert = {{(VERT_W-COORD_W-1-MID_SHIFT){s[COORD_W]}}, s, {MID_SHIFT{1'b0}}}
                 + push;
   endfunction

   // Stage valid bits and advance strobes
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in;
   logic en1, en2, en3, en4, en5;
   btct_adv_type adv;

   // Stage 1: input beat
   logic signed [COORD_W-1:0] px1_ff, py1_ff, ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic signed [COORD_W-1:0] cx1_ff, cy1_ff;
   logic        [BULGE_W-1:0] bulge1_ff, bulge1_in;

   // Stage 2: hexagon vertices, scaled point, winding deltas
   logic signed [VERT_W-1:0]  hx2_ff [6];
   logic signed [VERT_W-1:0]  hy2_ff [6];
   logic signed [VERT_W-1:0]  hx2_in [6];
   logic signed [VERT_W-1:0]  hy2_in [6];
   logic signed [VERT_W-1:0]  px2_ff, px2_in, py2_ff, py2_in;
   logic signed [WDIFF_W-1:0] dxab2_ff, dxab2_in, dyab2_ff, dyab2_in;
   logic signed [WDIFF_W-1:0] dxac2_ff, dxac2_in, dyac2_ff, dyac2_in;

   // Stage 3: winding products
   logic signed [WPROD_W-1:0] w1_3_ff, w1_3_in, w2_3_ff, w2_3_in;

   // Stage 4: winding sign
   logic signed [WSUM_W-1:0]  wsum;
   logic                      wpos4_ff, wpos4_in, wneg4_ff, wneg4_in;

   // Stage 5: result
   btct_sign_type             edge_sign [6];
   logic                      outside;
   logic                      inside5_ff, inside5_in, degen5_ff, degen5_in;

   // Advance a stage when it is empty or the next one moves
   always_comb begin
      en5       = !v5_ff || !rsp_stall;
      en4       = !v4_ff || en5;
      en3       = !v3_ff || en4;
      en2       = !v2_ff || en3;
      en1       = !v1_ff || en2;
      adv.s3    = en3;
      adv.s4    = en4;
      req_stall = !en1;
   end

   always_comb begin
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? v1_ff     : v2_ff;
      v3_in = en3 ? v2_ff     : v3_ff;
      v4_in = en4 ? v3_ff     : v4_ff;
      v5_in = en5 ? v4_ff     : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Stage 1: capture the beat, clamp the bulge to full
   always_comb begin
      bulge1_in = (req_bulge_amount > BULGE_FULL) ? BULGE_FULL : req_bulge_amount;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px1_ff    <= req_point_x;
         py1_ff    <= req_point_y;
         ax1_ff    <= req_corner_a_x;
         ay1_ff    <= req_corner_a_y;
         bx1_ff    <= req_corner_b_x;
         by1_ff    <= req_corner_b_y;
         cx1_ff    <= req_corner_c_x;
         cy1_ff    <= req_corner_c_y;
         bulge1_ff <= bulge1_in;
      end
   end

   // Stage 2: build the hexagon A, M_AB, B, M_BC, C, M_CA
   always_comb begin
      hx2_in[0] = corner_vert(ax1_ff);
      hy2_in[0] = corner_vert(ay1_ff);
      hx2_in[1] = mid_vert(ax1_ff, bx1_ff, cx1_ff, bulge1_ff);
      hy2_in[1] = mid_vert(ay1_ff, by1_ff, cy1_ff, bulge1_ff);
      hx2_in[2] = corner_vert(bx1_ff);
      hy2_in[2] = corner_vert(by1_ff);
      hx2_in[3] = mid_vert(bx1_ff, cx1_ff, ax1_ff, bulge1_ff);
      hy2_in[3] = mid_vert(by1_ff, cy1_ff, ay1_ff, bulge1_ff);
      hx2_in[4] = corner_vert(cx1_ff);
      hy2_in[4] = corner_vert(cy1_ff);
      hx2_in[5] = mid_vert(cx1_ff, ax1_ff, bx1_ff, bulge1_ff);
      hy2_in[5] = mid_vert(cy1_ff, ay1_ff, by1_ff, bulge1_ff);
      px2_in    = corner_vert(px1_ff);
      py2_in    = corner_vert(py1_ff);
      dxab2_in  = {bx1_ff[COORD_W-1], bx1_ff} - {ax1_ff[COORD_W-1], ax1_ff};
      dyab2_in  = {by1_ff[COORD_W-1], by1_ff} - {ay1_ff[COORD_W-1], ay1_ff};
      dxac2_in  = {cx1_ff[COORD_W-1], cx1_ff} - {ax1_ff[COORD_W-1], ax1_ff};
      dyac2_in  = {cy1_ff[COORD_W-1], cy1_ff} - {ay1_ff[COORD_W-1], ay1_ff};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int i = 0; i < 6; i++) begin
            hx2_ff[i] <= hx2_in[i];
            hy2_ff[i] <= hy2_in[i];
         end
         px2_ff   <= px2_in;
         py2_ff   <= py2_in;
         dxab2_ff <= dxab2_in;
         dyab2_ff <= dyab2_in;
         dxac2_ff <= dxac2_in;
         dyac2_ff <= dyac2_in;
      end
   end

   // Stage 3: winding products
   always_comb begin
      w1_3_in = WPROD_W'(dxab2_ff) * WPROD_W'(dyac2_ff);
      w2_3_in = WPROD_W'(dyab2_ff) * WPROD_W'(dxac2_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         w1_3_ff <= w1_3_in;
         w2_3_ff <= w2_3_in;
      end
   end

   // Stage 4: winding sign
   always_comb begin
      wsum     = {w1_3_ff[WPROD_W-1], w1_3_ff} - {w2_3_ff[WPROD_W-1], w2_3_ff};
      wneg4_in = wsum[WSUM_W-1];
      wpos4_in = !wsum[WSUM_W-1] && (wsum != '0);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         wpos4_ff <= wpos4_in;
         wneg4_ff <= wneg4_in;
      end
   end

   // Edge units: stages 3 and 4 for each hexagon edge
   for (genvar g = 0; g < 6; g++) begin : g_edge
      localparam int NEXT = (g == 5) ? 0 : g + 1;
      btct_edge_test u_edge (
         .clock      (clock),
         .adv        (adv),
         .start_x    (hx2_ff[g]),
         .start_y    (hy2_ff[g]),
         .end_x      (hx2_ff[NEXT]),
         .end_y      (hy2_ff[NEXT]),
         .pt_x       (px2_ff),
         .pt_y       (py2_ff),
         .cross_sign (edge_sign[g])
      );
   end

   // Stage 5: drop the point if any edge sees it on the wrong side
   always_comb begin
      outside = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if ((wpos4_ff && edge_sign[i].neg) || (wneg4_ff && edge_sign[i].pos)) begin
            outside = 1'b1;
         end
      end
      degen5_in  = !wpos4_ff && !wneg4_ff;
      inside5_in = !degen5_in && !outside;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         inside5_ff <= inside5_in;
         degen5_ff  <= degen5_in;
      end
   end

   assign rsp_valid      = v5_ff;
   assign rsp_inside_res = inside5_ff;
   assign rsp_degenerate = degen5_ff;

   // A degenerate triangle never reports inside
   a_degen_outside : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> !rsp_inside_res)
      else $error("degenerate result reported inside");

   // An open result side always lets the input through
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result side is open");

   // Input stalls only with a full first stage
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with empty first stage");

   // Winding sign flags exclude each other
   a_wind_sign : assert property (@(posedge clock) disable iff (reset)
      !(wpos4_ff && wneg4_ff))
      else $error("winding both positive and negative");

   // Pipeline comes out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> hdl/btct_edge_test.sv
// One hexagon edge: deltas, two cross-product multiplies and the sign of the cross.
module btct_edge_test
   import btct_pkg::*;
(
   input  logic                     clock,
   input  btct_adv_type             adv,
   input  logic signed [VERT_W-1:0] start_x,
   input  logic signed [VERT_W-1:0] start_y,
   input  logic signed [VERT_W-1:0] end_x,
   input  logic signed [VERT_W-1:0] end_y,
   input  logic signed [VERT_W-1:0] pt_x,
   input  logic signed [VERT_W-1:0] pt_y,
   output btct_sign_type            cross_sign
);

   logic signed [DIFF_W-1:0]  ex_ff, ex_in;
   logic signed [DIFF_W-1:0]  ey_ff, ey_in;
   logic signed [DIFF_W-1:0]  qx_ff, qx_in;
   logic signed [DIFF_W-1:0]  qy_ff, qy_in;
   logic signed [PROD_W-1:0]  m1_ff, m1_in;
   logic signed [PROD_W-1:0]  m2_ff, m2_in;
   logic signed [CROSS_W-1:0] cross_diff;

   // Edge vector and point offset from the edge start
   always_comb begin
      ex_in = {end_x[VERT_W-1], end_x} - {start_x[VERT_W-1], start_x};
      ey_in = {end_y[VERT_W-1], end_y} - {start_y[VERT_W-1], start_y};
      qx_in = {pt_x[VERT_W-1], pt_x} - {start_x[VERT_W-1], start_x};
      qy_in = {pt_y[VERT_W-1], pt_y} - {start_y[VERT_W-1], start_y};
   end

   // Two partial cross terms, one multiply each
   always_comb begin
      m1_in = PROD_W'(ex_ff) * PROD_W'(qy_ff);
      m2_in = PROD_W'(ey_ff) * PROD_W'(qx_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
      if (adv.s4) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   // Cross product and its sign
   always_comb begin
      cross_diff     = {m1_ff[PROD_W-1], m1_ff} - {m2_ff[PROD_W-1], m2_ff};
      cross_sign.neg = cross_diff[CROSS_W-1];
      cross_sign.pos = !cross_diff[CROSS_W-1] && (cross_diff != '0);
   end

endmodule
